// ===== rtl/scs_pkg.sv =====
// Shared constants, codes, types and helpers of the stack cache spill/fill block.
`default_nettype none

package scs_pkg;

  // Scratchpad geometry and request cap
  localparam int unsigned CACHE_WORDS  = 512;
  localparam int unsigned IDX_W        = $clog2(CACHE_WORDS);
  localparam int unsigned MAX_REQ      = 63;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned CFG_W        = 4;
  localparam int unsigned LOG2_MIN     = 2;
  localparam int unsigned LOG2_MAX     = IDX_W;
  localparam logic [31:0] WORD_BYTES   = 32'd4;

  // Input command codes
  localparam logic [2:0] CMD_RESERVE = 3'd0;
  localparam logic [2:0] CMD_ENSURE  = 3'd1;
  localparam logic [2:0] CMD_FREE    = 3'd2;
  localparam logic [2:0] CMD_FILL    = 3'd3;
  localparam logic [2:0] CMD_INIT    = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_SPILL = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef struct packed {
    logic accept;
    logic calc;
    logic sp_rd;
    logic sp_emit;
    logic req_emit;
    logic done_emit;
    logic clear;
  } scs_cmd_t;

  typedef struct packed {
    logic calc_zero;
    logic op_reserve;
    logic cnt_one;
    logic out_free;
    logic clr_last;
    logic in_fill;
  } scs_sts_t;

  // Positive part of a byte difference, in words, capped at MAX_REQ
  function automatic logic [CNT_W-1:0] words_of(input logic [31:0] diff);
    logic [29:0] w;
    w = diff[31:2];
    if (diff == 32'd0 || diff[31]) begin
      return '0;
    end else if (w > 30'(MAX_REQ)) begin
      return CNT_W'(MAX_REQ);
    end else begin
      return w[CNT_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stack_cache_spill_fill_top.sv =====
// Top level of the stack cache spill/fill controller.
// Input channel (in_valid_i/in_ready_o) takes one command beat: reserve, ensure,
// free, fill or init. Output channel (out_valid_o/out_ready_i) returns spill
// writes, fill read requests and one done beat (last_o high) per non-fill
// command; a fill beat writes the scratchpad ring and returns nothing.
// Each spill of a reserve waits on the registered read of the ring memory;
// the count k of spills or requests of a command is at most 63.
// The done beat sits in the output register while the next command is taken.
// A stalled receiver holds the output register and the sequence waits on it.
// cfg_we_i/cfg_wdata_i write the scratchpad size log2; write it
// only while no command is in flight.
// After reset the ring is cleared to zero, one word per cycle, all 512 words;
// in_ready_o stays low until this pass ends.
`default_nettype none

module stack_cache_spill_fill_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [5:0]  word_count_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] fill_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      mem_address_o,
  output logic [31:0]      spill_data_o,
  output logic [31:0]      stack_top_out_o,
  output logic [31:0]      mem_top_out_o,
  output logic             last_o
);
  import scs_pkg::*;

  scs_cmd_t cmd;
  scs_sts_t sts;

  scs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  scs_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .word_count_i   (word_count_i),
    .address_i      (address_i),
    .fill_data_i    (fill_data_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .mem_address_o  (mem_address_o),
    .spill_data_o   (spill_data_o),
    .stack_top_out_o(stack_top_out_o),
    .mem_top_out_o  (mem_top_out_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

// ===== rtl/scs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/scs_ctrl.sv =====
// Controller state machine: sequences clear, accept, count, transfers and done.
`default_nettype none

module scs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire scs_pkg::scs_sts_t sts_i,
  output scs_pkg::scs_cmd_t      cmd_o
);
  import scs_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_SP_RD  = 3'd3;
  localparam logic [2:0] ST_SP_OUT = 3'd4;
  localparam logic [2:0] ST_REQ    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // a fill beat only writes the ring
          if (!sts_i.in_fill) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        if (sts_i.calc_zero) begin
          state_d = ST_DONE;
        end else if (sts_i.op_reserve) begin
          state_d = ST_SP_RD;
        end else begin
          state_d = ST_REQ;
        end
      end
      ST_SP_RD: begin
        cmd_o.sp_rd = 1'b1;
        state_d     = ST_SP_OUT;
      end
      ST_SP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.sp_emit = 1'b1;
          state_d       = sts_i.cnt_one ? ST_DONE : ST_SP_RD;
        end
      end
      ST_REQ: begin
        if (sts_i.out_free) begin
          cmd_o.req_emit = 1'b1;
          if (sts_i.cnt_one) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_emit = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && !sts_i.clr_last) |=> (state_q == ST_CLEAR))
    else $error("left the clearing pass early");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.sp_emit, cmd_o.req_emit, cmd_o.done_emit, cmd_o.clear, cmd_o.accept}))
    else $error("conflicting datapath commands");

  a_spill_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SP_OUT) |-> ($past(state_q) == ST_SP_RD || $past(state_q) == ST_SP_OUT))
    else $error("spill beat without a ring read");

endmodule

`default_nettype wire

// ===== rtl/scs_datapath.sv =====
// Datapath: tops, transfer count, scratchpad ring, config register and output register.
`default_nettype none

module scs_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [3:0]        cfg_wdata_i,
  input  wire logic [2:0]        command_i,
  input  wire logic [5:0]        word_count_i,
  input  wire logic [31:0]       address_i,
  input  wire logic [31:0]       fill_data_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [1:0]             kind_o,
  output logic [31:0]            mem_address_o,
  output logic [31:0]            spill_data_o,
  output logic [31:0]            stack_top_out_o,
  output logic [31:0]            mem_top_out_o,
  output logic                   last_o,
  input  wire scs_pkg::scs_cmd_t cmd_i,
  output scs_pkg::scs_sts_t      sts_o
);
  import scs_pkg::*;

  logic [CFG_W-1:0] cfg_log2_q;
  logic [CFG_W-1:0] log2_eff;
  logic [IDX_W:0]   mask_ext;
  logic [IDX_W-1:0] word_mask;
  logic [31:0]      scratch_bytes;

  logic [2:0]       op_q;
  logic [CNT_W-1:0] n_q, n_eff;
  logic [31:0]      stack_top_q, mem_top_q;
  logic [CNT_W-1:0] count_q, count_calc;
  logic [31:0]      diff, mt_dec, addr_al;
  logic [IDX_W-1:0] clr_idx_q;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic             out_valid_q;
  logic [1:0]       kind_q;
  logic [31:0]      mem_address_q, spill_data_q, stack_top_out_q, mem_top_out_q;
  logic             last_q;

  // Scratchpad size in use
  always_comb begin
    if (cfg_log2_q < CFG_W'(LOG2_MIN)) begin
      log2_eff = CFG_W'(LOG2_MIN);
    end else if (cfg_log2_q > CFG_W'(LOG2_MAX)) begin
      log2_eff = CFG_W'(LOG2_MAX);
    end else begin
      log2_eff = cfg_log2_q;
    end
  end

  assign mask_ext      = ((IDX_W+1)'(1) << log2_eff) - (IDX_W+1)'(1);
  assign word_mask     = mask_ext[IDX_W-1:0];
  assign scratch_bytes = WORD_BYTES << log2_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_log2_q <= CFG_W'(LOG2_MAX);
    end else if (cfg_we_i) begin
      cfg_log2_q <= cfg_wdata_i;
    end
  end

  assign n_eff   = (word_count_i > CNT_W'(MAX_REQ)) ? CNT_W'(MAX_REQ) : word_count_i;
  assign addr_al = {address_i[31:2], 2'b00};
  assign mt_dec  = mem_top_q - WORD_BYTES;

  // Byte shortfall or overflow that sets the transfer count
  always_comb begin
    if (op_q == CMD_RESERVE) begin
      diff = mem_top_q - stack_top_q - scratch_bytes;
    end else begin
      diff = 32'({n_q, 2'b00}) - (mem_top_q - stack_top_q);
    end
    if (op_q == CMD_RESERVE || op_q == CMD_ENSURE) begin
      count_calc = words_of(diff);
    end else begin
      count_calc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= CMD_INIT;
      n_q         <= '0;
      stack_top_q <= '0;
      mem_top_q   <= '0;
      count_q     <= '0;
      clr_idx_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_idx_q <= clr_idx_q + IDX_W'(1);
      end
      if (cmd_i.accept) begin
        op_q <= command_i;
        n_q  <= n_eff;
        case (command_i)
          CMD_RESERVE: stack_top_q <= stack_top_q - 32'({n_eff, 2'b00});
          CMD_FREE:    stack_top_q <= stack_top_q + 32'({n_eff, 2'b00});
          CMD_INIT: begin
            stack_top_q <= addr_al;
            mem_top_q   <= addr_al;
          end
          default: ;
        endcase
      end
      if (cmd_i.calc) begin
        count_q <= count_calc;
        // pull the memory top up to a freed stack top
        if (op_q == CMD_FREE && $signed(stack_top_q) > $signed(mem_top_q)) begin
          mem_top_q <= stack_top_q;
        end
      end
      if (cmd_i.sp_rd) begin
        mem_top_q <= mt_dec;
      end
      if (cmd_i.req_emit) begin
        mem_top_q <= mem_top_q + WORD_BYTES;
      end
      if (cmd_i.sp_emit || cmd_i.req_emit) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // Ring write: clearing pass or a returned fill word
  always_comb begin
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd_i.accept && command_i == CMD_FILL;
      ram_waddr = address_i[IDX_W+1:2] & word_mask;
      ram_wdata = fill_data_i;
    end
  end

  assign ram_re    = cmd_i.sp_rd;
  assign ram_raddr = mt_dec[IDX_W+1:2] & word_mask;

  scs_ram #(
    .WIDTH(32),
    .DEPTH(CACHE_WORDS)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.sp_emit || cmd_i.req_emit || cmd_i.done_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sp_emit || cmd_i.req_emit) begin
      kind_q          <= cmd_i.sp_emit ? KIND_SPILL : KIND_REQ;
      mem_address_q   <= mem_top_q;
      spill_data_q    <= cmd_i.sp_emit ? ram_rdata : 32'd0;
      stack_top_out_q <= '0;
      mem_top_out_q   <= '0;
      last_q          <= 1'b0;
    end else if (cmd_i.done_emit) begin
      kind_q          <= KIND_DONE;
      mem_address_q   <= '0;
      spill_data_q    <= '0;
      stack_top_out_q <= stack_top_q;
      mem_top_out_q   <= mem_top_q;
      last_q          <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign mem_address_o   = mem_address_q;
  assign spill_data_o    = spill_data_q;
  assign stack_top_out_o = stack_top_out_q;
  assign mem_top_out_o   = mem_top_out_q;
  assign last_o          = last_q;

  always_comb begin
    sts_o            = '0;
    sts_o.calc_zero  = (count_calc == '0);
    sts_o.op_reserve = (op_q == CMD_RESERVE);
    sts_o.cnt_one    = (count_q == CNT_W'(1));
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.clr_last   = (clr_idx_q == IDX_W'(CACHE_WORDS - 1));
    sts_o.in_fill    = (command_i == CMD_FILL);
  end

  a_tops_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stack_top_q[1:0] == 2'b00 && mem_top_q[1:0] == 2'b00)
    else $error("stack or memory top lost word alignment");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sp_emit || cmd_i.req_emit || cmd_i.done_emit) |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while a beat waits");

  a_transfer_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sp_emit || cmd_i.req_emit) |-> (count_q != '0))
    else $error("transfer beat with no count left");

endmodule

`default_nettype wire
